// File: hdl/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants of the numeric literal scanner
// Scan phases, radix codes and the ASCII codes the scanner looks at.
// ----------------------------------------------------------------------------
package nls_pkg;

  // Scan phase of the literal state machine
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGNS  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3
  } phase_e;

  // Number base selected by the literal prefix
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  // Character codes
  localparam logic [7:0] CHAR_PLUS   = 8'h2b;  // '+'
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;  // '-'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41; // 'A'
  localparam logic [7:0] CHAR_UPPER_F = 8'h46; // 'F'
  localparam logic [7:0] CHAR_LOWER_X = 8'h78; // 'x'
  localparam logic [7:0] CHAR_UPPER_X = 8'h58; // 'X'

  // Clears the lowercase bit so a-f folds onto A-F
  localparam logic [7:0] CASE_FOLD_MASK = 8'h5f;

  // Digit value of 'A'
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

endpackage

// File: hdl/nls_in_if.sv
// ----------------------------------------------------------------------------
// nls_in_if: character input channel
// Valid/ready channel carrying one source character and the token start flag.
// ----------------------------------------------------------------------------
interface nls_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       begin_token;

  modport source (output valid, output char_code, output begin_token, input ready);
  modport sink   (input valid, input char_code, input begin_token, output ready);

endinterface

// File: hdl/nls_out_if.sv
// ----------------------------------------------------------------------------
// nls_out_if: literal result channel
// Valid/ready channel carrying the found flag and the signed literal value.
// ----------------------------------------------------------------------------
interface nls_out_if #(
  parameter int VALUE_BITS = 16
);

  logic                         valid;
  logic                         ready;
  logic                         found;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output found, output value, input ready);
  modport sink   (input valid, input found, input value, output ready);

endinterface

// File: hdl/numeric_literal_scanner.sv
// ----------------------------------------------------------------------------
// numeric_literal_scanner: C-style integer literal scanner
// Consumes one character per transfer and emits one result per literal.
// ----------------------------------------------------------------------------
// The scanner takes one character per clock cycle unless the input side is
// stalled. A character is captured in an input register, and once the result
// slot is free a single pass of shift-add logic updates the scan state and,
// when the character ends the token, loads the result register. The input
// side stalls only while the result register holds a result that the sink
// has not taken and a captured character waits behind it. Signs '+'/'-' may
// lead the literal (any '-' makes it negative), a leading 0 selects octal
// and 0x/0X hex; the value wraps at VALUE_BITS bits. A character with
// begin_token high starts a new scan; characters outside a scan are dropped
// without a result.
// ----------------------------------------------------------------------------
module numeric_literal_scanner #(
  parameter int VALUE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  nls_in_if.sink    in_i,
  nls_out_if.source out_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_begin_q;

  // Scan state
  nls_pkg::phase_e phase_q, phase_d;
  nls_pkg::radix_e radix_q, radix_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  // Result register
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [VALUE_BITS-1:0] out_value_q;

  // Single-pass datapath signals
  logic                  advance;
  logic                  emit;
  logic                  emit_found;
  logic [VALUE_BITS-1:0] emit_value;
  nls_pkg::phase_e       ph_cur;
  nls_pkg::radix_e       rad_cur;
  logic                  neg_cur;
  logic [VALUE_BITS-1:0] acc_cur;
  logic [7:0]            char_fold;
  logic                  is_dec;
  logic                  is_hex_letter;
  logic                  is_x;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] digit_ext;
  logic [VALUE_BITS-1:0] acc_shift;
  logic                  digit_ok;

  // Handshake: the captured character moves on when the result slot is free
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q  <= in_i.char_code;
      in_begin_q <= in_i.begin_token;
    end
  end

  // Character classification
  assign char_fold     = in_char_q & nls_pkg::CASE_FOLD_MASK;
  assign is_dec        = in_char_q inside {[nls_pkg::CHAR_ZERO:nls_pkg::CHAR_NINE]};
  assign is_hex_letter = char_fold inside {[nls_pkg::CHAR_UPPER_A:nls_pkg::CHAR_UPPER_F]};
  assign is_x          = (in_char_q == nls_pkg::CHAR_LOWER_X) ||
                         (in_char_q == nls_pkg::CHAR_UPPER_X);
  assign digit         = is_dec ? 4'(in_char_q - nls_pkg::CHAR_ZERO)
                                : 4'(char_fold - nls_pkg::CHAR_UPPER_A) +
                                  nls_pkg::HEX_LETTER_BASE;
  assign digit_ext     = {{(VALUE_BITS-4){1'b0}}, digit};

  // Start of a token restarts the scan state
  assign ph_cur  = in_begin_q ? nls_pkg::PH_SIGNS  : phase_q;
  assign rad_cur = in_begin_q ? nls_pkg::RADIX_DEC : radix_q;
  assign neg_cur = in_begin_q ? 1'b0 : neg_q;
  assign acc_cur = in_begin_q ? '0 : acc_q;

  // Shift-add accumulate: base 10 as x8 + x2, base 8 and 16 as shifts
  always_comb begin
    case (rad_cur)
      nls_pkg::RADIX_HEX: acc_shift = acc_cur << 4;
      nls_pkg::RADIX_OCT: acc_shift = acc_cur << 3;
      default:            acc_shift = (acc_cur << 3) + (acc_cur << 1);
    endcase
  end

  assign digit_ok = is_dec || ((rad_cur == nls_pkg::RADIX_HEX) && is_hex_letter);

  // Next state and result
  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_value = '0;
    if (in_valid_q && advance) begin
      phase_d = ph_cur;
      radix_d = rad_cur;
      neg_d   = neg_cur;
      acc_d   = acc_cur;
      case (ph_cur)
        nls_pkg::PH_SIGNS: begin
          if (in_char_q == nls_pkg::CHAR_MINUS) begin
            neg_d = 1'b1;
          end else if (in_char_q == nls_pkg::CHAR_PLUS) begin
            neg_d = neg_cur;
          end else if (is_dec) begin
            acc_d = digit_ext;
            if (in_char_q == nls_pkg::CHAR_ZERO) begin
              radix_d = nls_pkg::RADIX_OCT;
              phase_d = nls_pkg::PH_ZERO;
            end else begin
              radix_d = nls_pkg::RADIX_DEC;
              phase_d = nls_pkg::PH_DIGITS;
            end
          end else begin
            // Signs with no digit: nothing recognized
            emit    = 1'b1;
            phase_d = nls_pkg::PH_IDLE;
          end
        end
        nls_pkg::PH_ZERO, nls_pkg::PH_DIGITS: begin
          if ((ph_cur == nls_pkg::PH_ZERO) && is_x) begin
            radix_d = nls_pkg::RADIX_HEX;
            phase_d = nls_pkg::PH_DIGITS;
          end else if (digit_ok) begin
            acc_d   = acc_shift + digit_ext;
            phase_d = nls_pkg::PH_DIGITS;
          end else begin
            // Terminator: report the literal with its sign
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_value = neg_cur ? (-acc_cur) : acc_cur;
            phase_d    = nls_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = nls_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nls_pkg::PH_IDLE;
      radix_q <= nls_pkg::RADIX_DEC;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_found_q <= emit_found;
      out_value_q <= emit_value;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.found = out_found_q;
  assign out_o.value = out_value_q;

  // Assertions
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_value_q == '0))
    else $error("result without a literal carries a nonzero value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled while the result slot is free");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (phase_q == nls_pkg::PH_IDLE && out_valid_q))
    else $error("scan not closed after a result");

endmodule

// File: tb/sv/nls_checker.sv
// ----------------------------------------------------------------------------
// nls_checker: result predictor and comparator for the literal scanner
// Watches both channels, predicts one result per finished scan from each
// character transfer, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module nls_checker #(
  parameter int VALUE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  nls_in_if    in_mon_i,
  nls_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic                         found;
    logic signed [VALUE_BITS-1:0] value;
  } literal_t;

  // Predicted scan state
  nls_pkg::phase_e       phase = nls_pkg::PH_IDLE;
  nls_pkg::radix_e       radix = nls_pkg::RADIX_DEC;
  logic                  neg   = 1'b0;
  logic [VALUE_BITS-1:0] acc   = '0;

  literal_t literal_q[$];
  int       mismatches = 0;

  // Advances the predicted scan by one character; returns 1 when the
  // character ends the token, with the literal in lit.
  function automatic bit scan_literal_char(input logic [7:0] ch, input logic bgn,
                                           output literal_t lit);
    logic [7:0] folded;
    logic [3:0] dig;
    logic [4:0] base;
    bit         is_digit;
    lit      = '0;
    folded   = ch & nls_pkg::CASE_FOLD_MASK;
    is_digit = 1'b0;
    dig      = '0;
    if (bgn) begin
      phase = nls_pkg::PH_SIGNS;
      neg   = 1'b0;
      radix = nls_pkg::RADIX_DEC;
      acc   = '0;
    end
    case (phase)
      nls_pkg::PH_SIGNS: begin
        if (ch == nls_pkg::CHAR_PLUS) return 1'b0;
        if (ch == nls_pkg::CHAR_MINUS) begin
          neg = 1'b1;
          return 1'b0;
        end
        if (ch >= nls_pkg::CHAR_ZERO && ch <= nls_pkg::CHAR_NINE) begin
          acc = VALUE_BITS'(ch - nls_pkg::CHAR_ZERO);
          if (ch == nls_pkg::CHAR_ZERO) begin
            radix = nls_pkg::RADIX_OCT;
            phase = nls_pkg::PH_ZERO;
          end else begin
            radix = nls_pkg::RADIX_DEC;
            phase = nls_pkg::PH_DIGITS;
          end
          return 1'b0;
        end
        // no digit after the signs
        phase = nls_pkg::PH_IDLE;
        return 1'b1;
      end
      nls_pkg::PH_ZERO, nls_pkg::PH_DIGITS: begin
        if (phase == nls_pkg::PH_ZERO) begin
          if (ch == nls_pkg::CHAR_LOWER_X || ch == nls_pkg::CHAR_UPPER_X) begin
            radix = nls_pkg::RADIX_HEX;
            phase = nls_pkg::PH_DIGITS;
            return 1'b0;
          end
          phase = nls_pkg::PH_DIGITS;
        end
        if (ch >= nls_pkg::CHAR_ZERO && ch <= nls_pkg::CHAR_NINE) begin
          is_digit = 1'b1;
          dig      = 4'(ch - nls_pkg::CHAR_ZERO);
        end else if (radix == nls_pkg::RADIX_HEX && folded >= nls_pkg::CHAR_UPPER_A &&
                     folded <= nls_pkg::CHAR_UPPER_F) begin
          is_digit = 1'b1;
          dig      = 4'(folded - nls_pkg::CHAR_UPPER_A) + nls_pkg::HEX_LETTER_BASE;
        end
        if (is_digit) begin
          // octal still weights 8 and 9 by eight
          base = (radix == nls_pkg::RADIX_HEX) ? 5'd16 :
                 (radix == nls_pkg::RADIX_OCT) ? 5'd8 : 5'd10;
          acc  = acc * VALUE_BITS'(base) + VALUE_BITS'(dig);
          return 1'b0;
        end
        lit.found = 1'b1;
        lit.value = neg ? -acc : acc;
        phase     = nls_pkg::PH_IDLE;
        return 1'b1;
      end
      default: begin
        // idle without a token start: character dropped
        phase = nls_pkg::PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // Predict on character transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    literal_t got, want, lit;
    if (!rst_ni) begin
      phase = nls_pkg::PH_IDLE;
      radix = nls_pkg::RADIX_DEC;
      neg   = 1'b0;
      acc   = '0;
      literal_q.delete();
      pending_o <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.found = out_mon_i.found;
        got.value = out_mon_i.value;
        if (literal_q.size() == 0) begin
          $error("result transfer with no literal pending: found %0d, value %0d",
                 got.found, got.value);
          mismatches++;
        end else begin
          want = literal_q.pop_front();
          if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
            mismatches++;
          end
          if (got.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d", want.value, got.value);
            mismatches++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (scan_literal_char(in_mon_i.char_code, in_mon_i.begin_token, lit))
          literal_q.push_back(lit);
      end
      pending_o <= literal_q.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level of the literal scanner testbench
// Drives directed and random character streams with random idling on both
// channels; the checker beside the scanner predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VALUE_BITS  = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 284;
  localparam int DRAIN_WAIT  = 10;

  logic clk_i;
  logic rst_ni;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int items_sent   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  nls_in_if                               in_if ();
  nls_out_if #(.VALUE_BITS(VALUE_BITS))   out_if ();

  numeric_literal_scanner #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  nls_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_if),
    .out_mon_i   (out_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One character transfer, after a random number of idle cycles
  task automatic send_char(input logic [7:0] ch, input logic bgn, input bit counted);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.char_code   <= ch;
    in_if.begin_token <= bgn;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  // Sends a string, the first character starting the token
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, 1'b1);
  endtask

  // Holds the sender off until every predicted literal has arrived
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    logic [7:0] r;
    r = 8'($urandom_range(5));
    case ($urandom_range(4))
      0, 1:    return nls_pkg::CHAR_ZERO + 8'($urandom_range(9));
      2:       return nls_pkg::CHAR_UPPER_A + r;
      3:       return nls_pkg::CHAR_UPPER_A + 8'h20 + r;
      default: return nls_pkg::CHAR_UPPER_A + 8'h80 +
                      ($urandom_range(1) ? 8'h20 : 8'h00) + r;
    endcase
  endfunction

  // Mostly characters that end a token, sometimes any byte
  function automatic logic [7:0] rand_terminator();
    logic [7:0] punct [6] = '{8'h20, 8'h3b, 8'h2c, 8'h29, 8'h00, 8'hff};
    if ($urandom_range(2) == 0) return 8'($urandom_range(255));
    return punct[$urandom_range(5)];
  endfunction

  // One random token: signs, prefix, digits and an end character
  task automatic send_random_token();
    int         n_digits;
    int         kind;
    logic       bgn;
    logic [7:0] ch;
    bgn = 1'b1;
    // stray characters outside a scan
    if ($urandom_range(11) == 0) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
    end
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_char($urandom_range(1) ? nls_pkg::CHAR_MINUS : nls_pkg::CHAR_PLUS, bgn, 1'b1);
        bgn = 1'b0;
      end
    end
    n_digits = ($urandom_range(7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
    kind     = $urandom_range(9);
    if (kind < 4) begin
      send_char(nls_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)), bgn, 1'b1);
      repeat (n_digits) send_char(nls_pkg::CHAR_ZERO + 8'($urandom_range(9)), 1'b0, 1'b1);
    end else if (kind < 6) begin
      send_char(nls_pkg::CHAR_ZERO, bgn, 1'b1);
      repeat (n_digits) send_char(nls_pkg::CHAR_ZERO + 8'($urandom_range(9)), 1'b0, 1'b1);
    end else if (kind < 9) begin
      send_char(nls_pkg::CHAR_ZERO, bgn, 1'b1);
      send_char($urandom_range(1) ? nls_pkg::CHAR_LOWER_X : nls_pkg::CHAR_UPPER_X,
                1'b0, 1'b1);
      repeat (n_digits) send_char(rand_hex_digit(), 1'b0, 1'b1);
    end else begin
      // no digit at all: the end character may come straight away
      if (bgn) begin
        ch = rand_terminator();
        send_char(ch, 1'b1, 1'b1);
      end
    end
    // sometimes leave the scan open so the next start drops it
    if ($urandom_range(9) != 0) send_char(rand_terminator(), 1'b0, 1'b1);
  endtask

  // Stimulus and verdict
  initial begin
    int target;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.char_code   = '0;
    in_if.begin_token = 1'b0;
    out_if.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 20;
    rcv_idle_pct = 55;

    // directed: hex case mix, bare prefix, octal with 8/9, signs only,
    // idle character, restart mid-scan, sign run with wraparound
    send_text("0xFf,");
    send_text("0X)");
    send_text("089");
    send_char(8'hff, 1'b0, 1'b1);
    send_text("+-");
    send_char(8'h00, 1'b0, 1'b1);
    send_char(nls_pkg::CHAR_ZERO + 8'd5, 1'b0, 1'b1);
    send_text("12");
    send_text("3");
    send_char(8'h20, 1'b0, 1'b1);
    send_text("-+-65537 ");
    wait_drained();

    // random: three idling profiles, drained between them
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          snd_idle_pct = 20;
          rcv_idle_pct = 55;
        end
        1: begin
          snd_idle_pct = 55;
          rcv_idle_pct = 20;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_token();
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending != 0) $error("%0d literal results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
